// ----- rtl/utf8vd_pkg.sv -----
// Package: shared types and constants of the UTF-8 validating decoder.
`default_nettype none

package utf8vd_pkg;

    // Field widths
    localparam int unsigned BYTE_W = 8;
    localparam int unsigned CP_W   = 21;
    localparam int unsigned ERR_W  = 3;
    localparam int unsigned REM_W  = 2;
    localparam int unsigned CLS_W  = 2;

    // Stream widths: code point padded to whole bytes, tuser = {error_code, char_ready}
    localparam int unsigned S_TDATA_W = 8;
    localparam int unsigned M_TDATA_W = 24;
    localparam int unsigned M_TUSER_W = ERR_W + 1;

    // Error codes
    localparam logic [ERR_W-1:0] ERR_NONE       = 3'd0;
    localparam logic [ERR_W-1:0] ERR_BAD_LEAD   = 3'd1;
    localparam logic [ERR_W-1:0] ERR_INCOMPLETE = 3'd2;
    localparam logic [ERR_W-1:0] ERR_BAD_CONT   = 3'd3;
    localparam logic [ERR_W-1:0] ERR_INVALID    = 3'd4;
    localparam logic [ERR_W-1:0] ERR_LINE_BREAK = 3'd5;

    // Length classes (sequence length minus one)
    localparam logic [CLS_W-1:0] CLS_ONE   = 2'd0;
    localparam logic [CLS_W-1:0] CLS_TWO   = 2'd1;
    localparam logic [CLS_W-1:0] CLS_THREE = 2'd2;
    localparam logic [CLS_W-1:0] CLS_FOUR  = 2'd3;

    // Value limits
    localparam logic [CP_W-1:0] MIN_TWO     = 21'h00080;
    localparam logic [CP_W-1:0] MIN_THREE   = 21'h00800;
    localparam logic [CP_W-1:0] MIN_FOUR    = 21'h10000;
    localparam logic [CP_W-1:0] MAX_CP      = 21'h10FFFF;
    localparam logic [CP_W-1:0] SURR_LO     = 21'h0D800;
    localparam logic [CP_W-1:0] SURR_HI     = 21'h0DFFF;
    localparam logic [CP_W-1:0] CP_LF       = 21'h0000A;
    localparam logic [CP_W-1:0] CP_CR       = 21'h0000D;

    // Decoder mode
    typedef enum logic [1:0] {
        MODE_IDLE    = 2'd0,
        MODE_COLLECT = 2'd1,
        MODE_DISCARD = 2'd2
    } t_mode;

endpackage

`default_nettype wire

// ----- rtl/utf8_validating_decoder_unit.sv -----
// Top level: strict UTF-8 decoder, one byte per request in, zero or one result out.
//
//  channel | dir | tdata                    | tuser                      | tlast
//  s_axis  | in  | [7:0] text_byte          | -                          | final_byte
//  m_axis  | out | [20:0] code_point, pad 0 | [0] char_ready, [3:1] error | string_end
//
// One byte is accepted per cycle while the input is ready; its result, if any,
// sits in the output register in the cycle after acceptance. Decode state and
// result are computed in one pass from the byte and the state registers.
// A stalled output holds its result; the input stays ready while the output
// register is empty or being drained in the same cycle.
// Synchronous active-low reset returns to idle with no pending result.
`default_nettype none

module utf8_validating_decoder_unit
    import utf8vd_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // Input byte stream
    input  wire logic                  i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    input  wire logic [S_TDATA_W-1:0]  i_s_axis_tdata,   // [7:0] text_byte
    input  wire logic                  i_s_axis_tlast,   // final_byte
    // Output result stream
    output logic                       o_m_axis_tvalid,
    input  wire logic                  i_m_axis_tready,
    output logic [M_TDATA_W-1:0]       o_m_axis_tdata,   // [20:0] code_point, [23:21] zero
    output logic [M_TUSER_W-1:0]       o_m_axis_tuser,   // [0] char_ready, [3:1] error_code
    output logic                       o_m_axis_tlast    // string_end
);

    // Decode state
    t_mode             r_mode,  n_mode;
    logic [REM_W-1:0]  r_rem,   n_rem;
    logic [CP_W-1:0]   r_acc,   n_acc;
    logic [CLS_W-1:0]  r_cls,   n_cls;
    logic [ERR_W-1:0]  r_herr,  n_herr;

    // Result register
    logic              r_out_valid;
    logic [CP_W-1:0]   r_cp,    n_cp;
    logic              r_rdy,   n_rdy;
    logic [ERR_W-1:0]  r_err,   n_err;
    logic              r_end,   n_end;
    logic              emit;

    logic              in_fire;
    logic              out_fire;
    logic [BYTE_W-1:0] b;
    logic              fin;

    // Finish-check inputs and outcomes
    logic [CP_W-1:0]   chk_cp;
    logic [CLS_W-1:0]  chk_cls;
    logic [CP_W-1:0]   chk_min;
    logic              chk_bad;
    logic              chk_brk;

    // Per-mode scratch values
    logic [ERR_W-1:0]  coll_err;
    logic [CP_W-1:0]   coll_acc;
    logic [REM_W-1:0]  coll_rem;
    logic [CLS_W-1:0]  lead_cls;
    logic [CP_W-1:0]   lead_pay;
    logic              lead_bad;

    assign b        = i_s_axis_tdata;
    assign fin      = i_s_axis_tlast;
    assign out_fire = r_out_valid & i_m_axis_tready;
    assign o_s_axis_tready = ~r_out_valid | i_m_axis_tready;
    assign in_fire  = i_s_axis_tvalid & o_s_axis_tready;

    // Classify the lead byte
    always_comb begin
        lead_bad = 1'b0;
        lead_cls = CLS_ONE;
        lead_pay = CP_W'(b);
        if (b[7] == 1'b0) begin
            lead_cls = CLS_ONE;
            lead_pay = CP_W'(b[6:0]);
        end else if (b[7:5] == 3'b110) begin
            lead_cls = CLS_TWO;
            lead_pay = CP_W'(b[4:0]);
        end else if (b[7:4] == 4'b1110) begin
            lead_cls = CLS_THREE;
            lead_pay = CP_W'(b[3:0]);
        end else if (b[7:3] == 5'b11110) begin
            lead_cls = CLS_FOUR;
            lead_pay = CP_W'(b[2:0]);
        end else begin
            lead_bad = 1'b1;
        end
    end

    // Gather a continuation byte
    always_comb begin
        coll_err = r_herr;
        if (r_herr == ERR_NONE && b[7:6] != 2'b10) begin
            coll_err = ERR_BAD_CONT;
        end
        coll_acc = {r_acc[CP_W-7:0], b[5:0]};
        coll_rem = r_rem - REM_W'(1);
    end

    // Select the value to check: a one-byte lead or a completed sequence
    always_comb begin
        if (r_mode == MODE_IDLE) begin
            chk_cp  = lead_pay;
            chk_cls = CLS_ONE;
        end else begin
            chk_cp  = coll_acc;
            chk_cls = r_cls;
        end
        case (chk_cls)
            CLS_TWO:   chk_min = MIN_TWO;
            CLS_THREE: chk_min = MIN_THREE;
            CLS_FOUR:  chk_min = MIN_FOUR;
            default:   chk_min = '0;
        endcase
        chk_bad = (chk_cp < chk_min) || (chk_cp > MAX_CP) ||
                  (chk_cp >= SURR_LO && chk_cp <= SURR_HI);
        chk_brk = (chk_cp == CP_LF) || (chk_cp == CP_CR);
    end

    // Next decode state and result
    always_comb begin
        n_mode = r_mode;
        n_rem  = r_rem;
        n_acc  = r_acc;
        n_cls  = r_cls;
        n_herr = r_herr;
        emit   = 1'b0;
        n_cp   = '0;
        n_rdy  = 1'b0;
        n_err  = ERR_NONE;
        n_end  = fin;

        case (r_mode)
            MODE_IDLE: begin
                if (lead_bad) begin
                    emit  = 1'b1;
                    n_err = ERR_BAD_LEAD;
                end else if (lead_cls == CLS_ONE) begin
                    emit  = 1'b1;
                    if (chk_bad) begin
                        n_err = ERR_INVALID;
                    end else if (chk_brk) begin
                        n_err = ERR_LINE_BREAK;
                    end else begin
                        n_cp  = chk_cp;
                        n_rdy = 1'b1;
                    end
                end else if (fin) begin
                    emit  = 1'b1;
                    n_err = ERR_INCOMPLETE;
                end else begin
                    n_mode = MODE_COLLECT;
                    n_cls  = lead_cls;
                    n_rem  = lead_cls;
                    n_acc  = lead_pay;
                    n_herr = ERR_NONE;
                end
            end
            MODE_COLLECT: begin
                n_herr = coll_err;
                n_acc  = coll_acc;
                n_rem  = coll_rem;
                if (coll_rem == '0) begin
                    emit = 1'b1;
                    if (coll_err != ERR_NONE) begin
                        n_err = coll_err;
                    end else if (chk_bad) begin
                        n_err = ERR_INVALID;
                    end else if (chk_brk) begin
                        n_err = ERR_LINE_BREAK;
                    end else begin
                        n_cp  = chk_cp;
                        n_rdy = 1'b1;
                    end
                end else if (fin) begin
                    emit  = 1'b1;
                    n_err = ERR_INCOMPLETE;
                end
            end
            default: begin
                // discarding: report the held error again on the final byte
                if (fin) begin
                    emit  = 1'b1;
                    n_err = r_herr;
                end
            end
        endcase

        // Route the state after a result
        if (emit) begin
            if (fin) begin
                n_mode = MODE_IDLE;
                n_rem  = '0;
                n_acc  = '0;
                n_cls  = CLS_ONE;
                n_herr = ERR_NONE;
            end else if (n_err != ERR_NONE) begin
                n_mode = MODE_DISCARD;
                n_rem  = '0;
                n_herr = n_err;
            end else begin
                n_mode = MODE_IDLE;
                n_rem  = '0;
                n_acc  = '0;
                n_cls  = CLS_ONE;
                n_herr = ERR_NONE;
            end
        end
    end

    // Advance decode state on each accepted request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_IDLE;
            r_rem  <= '0;
            r_acc  <= '0;
            r_cls  <= CLS_ONE;
            r_herr <= ERR_NONE;
        end else if (in_fire) begin
            r_mode <= n_mode;
            r_rem  <= n_rem;
            r_acc  <= n_acc;
            r_cls  <= n_cls;
            r_herr <= n_herr;
        end
    end

    // Hold the result until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_fire && emit) begin
            r_out_valid <= 1'b1;
        end else if (out_fire) begin
            r_out_valid <= 1'b0;
        end
    end

    // Load result payload
    always_ff @(posedge i_clk) begin
        if (in_fire && emit) begin
            r_cp  <= n_cp;
            r_rdy <= n_rdy;
            r_err <= n_err;
            r_end <= n_end;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = M_TDATA_W'(r_cp);
    assign o_m_axis_tuser  = {r_err, r_rdy};
    assign o_m_axis_tlast  = r_end;

endmodule

`default_nettype wire

// ----- rtl/utf8vd_checker.sv -----
// Checker: port-level properties of the UTF-8 decoder, bound to the top level.
`default_nettype none

module utf8vd_checker
    import utf8vd_pkg::*;
(
    input wire logic                  i_clk,
    input wire logic                  i_rst_n,
    input wire logic                  i_s_axis_tvalid,
    input wire logic                  o_s_axis_tready,
    input wire logic                  i_s_axis_tlast,
    input wire logic                  o_m_axis_tvalid,
    input wire logic                  i_m_axis_tready,
    input wire logic [M_TDATA_W-1:0]  o_m_axis_tdata,
    input wire logic [M_TUSER_W-1:0]  o_m_axis_tuser,
    input wire logic                  o_m_axis_tlast
);

    // Hold a stalled result
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser)
            && $stable(o_m_axis_tlast))
        else $error("result changed while stalled");

    // A final byte always closes its string with one result
    a_final_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready && i_s_axis_tlast |=>
            o_m_axis_tvalid && o_m_axis_tlast)
        else $error("final byte without closing result");

    // A completed character carries no error
    a_char_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser[0] |-> o_m_axis_tuser[M_TUSER_W-1:1] == ERR_NONE)
        else $error("character result with error code");

    // A result without a character shows code point zero and some error or end
    a_no_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tuser[0] |->
            o_m_axis_tdata == '0 &&
            (o_m_axis_tuser[M_TUSER_W-1:1] != ERR_NONE || o_m_axis_tlast))
        else $error("empty result malformed");

    // A delivered code point is a valid scalar value other than CR or LF
    a_scalar: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser[0] |->
            o_m_axis_tdata[CP_W-1:0] <= MAX_CP &&
            (o_m_axis_tdata[CP_W-1:0] < SURR_LO || o_m_axis_tdata[CP_W-1:0] > SURR_HI) &&
            o_m_axis_tdata[CP_W-1:0] != CP_LF && o_m_axis_tdata[CP_W-1:0] != CP_CR)
        else $error("invalid code point delivered");

endmodule

bind utf8_validating_decoder_unit utf8vd_checker u_utf8vd_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .i_s_axis_tlast  (i_s_axis_tlast),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser),
    .o_m_axis_tlast  (o_m_axis_tlast)
);

`default_nettype wire
